FILE: rtl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg
// Types and constants shared by the dark-run rectangle merger modules.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int CoordW     = 11;
  localparam int PixW       = 8;
  localparam int IdxW       = 9;
  localparam int RectCountW = 10;
  localparam int OpW        = 2;
  localparam int MaxCols    = 2048;
  localparam int MaxRows    = 2048;

  typedef enum logic [OpW-1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  // query handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              rd;
    logic              done;
    logic              app;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] row;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] rd_left;
    logic [CoordW-1:0] rd_top;
    logic [CoordW-1:0] rd_right;
    logic [CoordW-1:0] rd_bottom;
  } tok_t;

endpackage

FILE: rtl/drm_cell.sv
// ----------------------------------------------------------------------------
// drm_cell
// One rectangle table entry; grows, appends or reads out for a passing query.
// ----------------------------------------------------------------------------
module drm_cell #(
  parameter int Index = 0,
  parameter int CntW  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CntW-1:0]   count_i,
  input  drm_pkg::tok_t     tok_i,
  output drm_pkg::tok_t     tok_o
);
  import drm_pkg::*;

  localparam int CmpW = (CntW > IdxW) ? CntW : IdxW;
  localparam logic [CntW-1:0] K    = CntW'(Index);
  localparam logic [CmpW-1:0] KCmp = CmpW'(Index);

  logic [CoordW-1:0] left_q, top_q, right_q, bottom_q;
  logic              grow, fill;
  tok_t              tok_d, tok_q;

  always_comb begin
    tok_d = tok_i;
    grow  = 1'b0;
    fill  = 1'b0;
    if (tok_i.vld && !tok_i.rd && !tok_i.done) begin
      if ((K < count_i) && (tok_i.row != '0) &&
          (bottom_q == tok_i.row - CoordW'(1)) &&
          (left_q == tok_i.left) && (right_q == tok_i.right)) begin
        grow       = 1'b1;
        tok_d.done = 1'b1;
      end else if (K == count_i) begin
        fill       = 1'b1;
        tok_d.done = 1'b1;
        tok_d.app  = 1'b1;
      end
    end
    if (tok_i.vld && tok_i.rd && (KCmp == CmpW'(tok_i.idx))) begin
      tok_d.rd_left   = left_q;
      tok_d.rd_top    = top_q;
      tok_d.rd_right  = right_q;
      tok_d.rd_bottom = bottom_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      left_q   <= tok_i.left;
      top_q    <= tok_i.row;
      right_q  <= tok_i.right;
      bottom_q <= tok_i.row;
    end else if (grow) begin
      bottom_q <= tok_i.row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/drm_ctrl.sv
// ----------------------------------------------------------------------------
// drm_ctrl
// Run detection, row/column tracking, query launch and result register.
// ----------------------------------------------------------------------------
module drm_ctrl #(
  parameter int MAX_RECTS = 512,
  parameter int CntW      = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [drm_pkg::OpW-1:0]         opcode_i,
  input  logic [drm_pkg::PixW-1:0]        pixel_value_i,
  input  logic                            row_end_i,
  input  logic [drm_pkg::IdxW-1:0]        entry_index_i,
  input  logic                            dark_level_we_i,
  input  logic [drm_pkg::PixW-1:0]        dark_level_i,
  output logic [CntW-1:0]                 count_o,
  output drm_pkg::tok_t                   tok_o,
  input  drm_pkg::tok_t                   tok_i,
  output logic                            result_strobe_o,
  output logic [drm_pkg::CoordW-1:0]      x_left_o,
  output logic [drm_pkg::CoordW-1:0]      y_top_o,
  output logic [drm_pkg::CoordW-1:0]      x_right_o,
  output logic [drm_pkg::CoordW-1:0]      y_bottom_o,
  output logic                            entry_valid_o,
  output logic [drm_pkg::RectCountW-1:0]  rect_count_o,
  output logic                            overflowed_o
);
  import drm_pkg::*;

  localparam int WalkW = $clog2(MAX_RECTS + 1);
  localparam int CmpW  = (CntW > IdxW) ? CntW : IdxW;
  localparam logic [CoordW-1:0] LastCol = CoordW'(MaxCols - 1);
  localparam logic [CoordW-1:0] LastRow = CoordW'(MaxRows - 1);
  localparam logic [WalkW-1:0]  WalkEnd = WalkW'(MAX_RECTS);

  state_e            state_q, state_d;
  logic [WalkW-1:0]  walk_q, walk_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CoordW-1:0] row_q, row_d, col_q, col_d, first_q, first_d;
  logic              inside_q, inside_d, ovf_q, ovf_d;
  logic [PixW-1:0]   dark_q;
  tok_t              tok_q, tok_d;
  logic              accept, dark, last, run_end;
  logic [CoordW-1:0] run_left, run_right;
  logic              res_d, res_q, valid_d, valid_q;
  logic [CoordW-1:0] xl_q, yt_q, xr_q, yb_q;
  logic [CntW-1:0]   rc_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign dark   = (pixel_value_i == dark_q);
  assign last   = row_end_i || (col_q == LastCol);

  always_comb begin
    run_end   = 1'b0;
    run_left  = first_q;
    run_right = col_q;
    if (dark) begin
      run_left = inside_q ? first_q : col_q;
      run_end  = last;
    end else if (inside_q) begin
      run_end   = 1'b1;
      run_right = col_q - CoordW'(1);
    end
  end

  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    count_d  = count_q;
    row_d    = row_q;
    col_d    = col_q;
    first_d  = first_q;
    inside_d = inside_q;
    ovf_d    = ovf_q;
    tok_d    = '0;
    res_d    = 1'b0;
    valid_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(opcode_i))
            OP_PIXEL: begin
              if (dark && !inside_q) begin
                inside_d = 1'b1;
                first_d  = col_q;
              end
              if (run_end || last) begin
                inside_d = 1'b0;
              end
              if (last) begin
                col_d = '0;
                if (row_q < LastRow) begin
                  row_d = row_q + CoordW'(1);
                end
              end else begin
                col_d = col_q + CoordW'(1);
              end
              if (run_end) begin
                tok_d.vld   = 1'b1;
                tok_d.left  = run_left;
                tok_d.right = run_right;
                tok_d.row   = row_q;
                state_d     = ST_WALK;
                walk_d      = '0;
              end
            end
            OP_READ: begin
              tok_d.vld = 1'b1;
              tok_d.rd  = 1'b1;
              tok_d.idx = entry_index_i;
              state_d   = ST_WALK;
              walk_d    = '0;
            end
            OP_CLEAR: begin
              count_d  = '0;
              row_d    = '0;
              col_d    = '0;
              first_d  = '0;
              inside_d = 1'b0;
              ovf_d    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_q == WalkEnd) begin
          state_d = ST_IDLE;
          if (tok_i.rd) begin
            res_d   = 1'b1;
            valid_d = CmpW'(tok_i.idx) < CmpW'(count_q);
          end else if (tok_i.app) begin
            count_d = count_q + CntW'(1);
          end else if (!tok_i.done) begin
            ovf_d = 1'b1;
          end
        end else begin
          walk_d = walk_q + WalkW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      walk_q   <= '0;
      count_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      first_q  <= '0;
      inside_q <= 1'b0;
      ovf_q    <= 1'b0;
      dark_q   <= '0;
      tok_q    <= '0;
      res_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      count_q  <= count_d;
      row_q    <= row_d;
      col_q    <= col_d;
      first_q  <= first_d;
      inside_q <= inside_d;
      ovf_q    <= ovf_d;
      tok_q    <= tok_d;
      res_q    <= res_d;
      if (dark_level_we_i) begin
        dark_q <= dark_level_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_d) begin
      valid_q <= valid_d;
      xl_q    <= valid_d ? tok_i.rd_left   : '0;
      yt_q    <= valid_d ? tok_i.rd_top    : '0;
      xr_q    <= valid_d ? tok_i.rd_right  : '0;
      yb_q    <= valid_d ? tok_i.rd_bottom : '0;
      rc_q    <= count_q;
    end
  end

  assign busy_o          = (state_q == ST_WALK);
  assign count_o         = count_q;
  assign tok_o           = tok_q;
  assign result_strobe_o = res_q;
  assign x_left_o        = xl_q;
  assign y_top_o         = yt_q;
  assign x_right_o       = xr_q;
  assign y_bottom_o      = yb_q;
  assign entry_valid_o   = valid_q;
  assign rect_count_o    = RectCountW'(rc_q);
  assign overflowed_o    = ovf_q;

endmodule

FILE: rtl/dark_run_rectangle_merger_top.sv
// ----------------------------------------------------------------------------
// dark_run_rectangle_merger_top
// Cuts raster pixels into dark runs and merges them into rectangles held in
// a chain of table cells.
//
//   channel   signals                                      direction
//   command   start_i, busy_o, opcode_i, pixel_value_i,    in
//             row_end_i, entry_index_i
//   result    result_strobe_o, x_left_o .. overflowed_o    out
//   config    dark_level_we_i, dark_level_i                in
//
// a pixel that closes no run leaves busy_o low; a pixel that closes a run and a
// read keep busy_o high while the query walks the cell chain, one cell per
// cycle
// a read result is strobed for one cycle right after busy_o falls
// reset empties the table and clears dark_level; the result side never stalls
// ----------------------------------------------------------------------------
module dark_run_rectangle_merger_top #(
  parameter int MAX_RECTS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [drm_pkg::OpW-1:0]         opcode_i,
  input  logic [drm_pkg::PixW-1:0]        pixel_value_i,
  input  logic                            row_end_i,
  input  logic [drm_pkg::IdxW-1:0]        entry_index_i,
  input  logic                            dark_level_we_i,
  input  logic [drm_pkg::PixW-1:0]        dark_level_i,
  output logic                            result_strobe_o,
  output logic [drm_pkg::CoordW-1:0]      x_left_o,
  output logic [drm_pkg::CoordW-1:0]      y_top_o,
  output logic [drm_pkg::CoordW-1:0]      x_right_o,
  output logic [drm_pkg::CoordW-1:0]      y_bottom_o,
  output logic                            entry_valid_o,
  output logic [drm_pkg::RectCountW-1:0]  rect_count_o,
  output logic                            overflowed_o
);
  import drm_pkg::*;

  localparam int CntW = $clog2(MAX_RECTS + 1);

  logic [CntW-1:0] count;
  tok_t            tok [MAX_RECTS+1];

  drm_ctrl #(
    .MAX_RECTS (MAX_RECTS),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .pixel_value_i   (pixel_value_i),
    .row_end_i       (row_end_i),
    .entry_index_i   (entry_index_i),
    .dark_level_we_i (dark_level_we_i),
    .dark_level_i    (dark_level_i),
    .count_o         (count),
    .tok_o           (tok[0]),
    .tok_i           (tok[MAX_RECTS]),
    .result_strobe_o (result_strobe_o),
    .x_left_o        (x_left_o),
    .y_top_o         (y_top_o),
    .x_right_o       (x_right_o),
    .y_bottom_o      (y_bottom_o),
    .entry_valid_o   (entry_valid_o),
    .rect_count_o    (rect_count_o),
    .overflowed_o    (overflowed_o)
  );

  for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
    drm_cell #(
      .Index (k),
      .CntW  (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

endmodule
